/* src/i2c_master_sequencer_macros.svh */
// ----------------------------------------------------------------------------
// I2C master sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_SEQUENCER_MACROS_SVH
`define I2C_MASTER_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Widths, command and phase codes, register indexes and shared structs.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int REQ_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int TPU_W      = 8;
  localparam int TMO_W      = 10;
  localparam int PHASE_W    = 5;
  localparam int DLY_W      = 10;
  localparam int BIT_W      = 4;
  localparam int WAIT_W     = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT  = 1'd1;

  localparam logic [TPU_W-1:0] TPU_RESET     = 8'd1;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 10'd250;

  // Command codes.
  localparam logic [REQ_W-1:0] REQ_NONE  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_WRITE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_WAIT  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ  = 3'd5;

  // Sequencer phases.
  localparam logic [PHASE_W-1:0] PH_IDLE = 5'd0;
  localparam logic [PHASE_W-1:0] ST_A    = 5'd1;
  localparam logic [PHASE_W-1:0] ST_B    = 5'd2;
  localparam logic [PHASE_W-1:0] ST_C    = 5'd3;
  localparam logic [PHASE_W-1:0] ST_D    = 5'd4;
  localparam logic [PHASE_W-1:0] SP_A    = 5'd5;
  localparam logic [PHASE_W-1:0] SP_B    = 5'd6;
  localparam logic [PHASE_W-1:0] SP_C    = 5'd7;
  localparam logic [PHASE_W-1:0] SP_D    = 5'd8;
  localparam logic [PHASE_W-1:0] WA_A    = 5'd9;
  localparam logic [PHASE_W-1:0] WA_B    = 5'd10;
  localparam logic [PHASE_W-1:0] WA_POLL = 5'd11;
  localparam logic [PHASE_W-1:0] WA_END  = 5'd12;
  localparam logic [PHASE_W-1:0] WR_A    = 5'd13;
  localparam logic [PHASE_W-1:0] WR_B    = 5'd14;
  localparam logic [PHASE_W-1:0] WR_C    = 5'd15;
  localparam logic [PHASE_W-1:0] WR_D    = 5'd16;
  localparam logic [PHASE_W-1:0] RD_A    = 5'd17;
  localparam logic [PHASE_W-1:0] RD_B    = 5'd18;
  localparam logic [PHASE_W-1:0] RD_C    = 5'd19;
  localparam logic [PHASE_W-1:0] RD_D    = 5'd20;
  localparam logic [PHASE_W-1:0] AK_A    = 5'd21;
  localparam logic [PHASE_W-1:0] AK_B    = 5'd22;
  localparam logic [PHASE_W-1:0] AK_C    = 5'd23;
  localparam logic [PHASE_W-1:0] AK_D    = 5'd24;
  localparam logic [PHASE_W-1:0] AK_E    = 5'd25;

  localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [DLY_W-1:0]   delay_count;
    logic [BIT_W-1:0]   bit_count;
    logic [BYTE_W-1:0]  shift_reg;
    logic [WAIT_W-1:0]  wait_count;
    logic [BYTE_W-1:0]  received;
    logic               ack_failed;
    logic               scl_reg;
    logic               sda_reg;
    logic               sda_en_reg;
    logic               ack_choice;
  } seq_state_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_out;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_error;
    logic              cmd_rejected;
  } tick_res_t;

endpackage

/* src/i2cm_if.sv */
// ----------------------------------------------------------------------------
// I2C master sequencer channels
// Valid/ready channels for ticks, results and configuration writes.
// ----------------------------------------------------------------------------
interface i2cm_item_if;
  logic                          valid;
  logic                          ready;
  logic [i2cm_pkg::REQ_W-1:0]    req_type;
  logic [i2cm_pkg::BYTE_W-1:0]   tx_byte;
  logic                          send_ack;
  logic                          sda_level;

  modport source (output valid, req_type, tx_byte, send_ack, sda_level, input ready);
  modport sink   (input valid, req_type, tx_byte, send_ack, sda_level, output ready);
endinterface

interface i2cm_result_if;
  logic                          valid;
  logic                          ready;
  logic                          scl_level;
  logic                          sda_out;
  logic                          sda_drive;
  logic                          busy_res;
  logic                          done_res;
  logic [i2cm_pkg::BYTE_W-1:0]   rx_byte;
  logic                          ack_error;
  logic                          cmd_rejected;

  modport source (output valid, scl_level, sda_out, sda_drive, busy_res, done_res,
                  rx_byte, ack_error, cmd_rejected, input ready);
  modport sink   (input valid, scl_level, sda_out, sda_drive, busy_res, done_res,
                  rx_byte, ack_error, cmd_rejected, output ready);
endinterface

interface i2cm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [i2cm_pkg::CFG_IDX_W-1:0]    index;
  logic [i2cm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/i2cm_step.sv */
// ----------------------------------------------------------------------------
// I2C master sequencer tick step
// Next state and tick result for one tick, computed from the current state.
// ----------------------------------------------------------------------------
module i2cm_step (
  input  i2cm_pkg::seq_state_t             cur,
  input  logic [i2cm_pkg::REQ_W-1:0]       req_type,
  input  logic [i2cm_pkg::BYTE_W-1:0]      tx_byte,
  input  logic                             send_ack,
  input  logic                             sda_level,
  input  logic [i2cm_pkg::TPU_W-1:0]       ticks_per_us,
  input  logic [i2cm_pkg::TMO_W-1:0]       ack_timeout,
  output i2cm_pkg::seq_state_t             nxt,
  output i2cm_pkg::tick_res_t              res
);

  logic [i2cm_pkg::TPU_W-1:0] tpu;
  logic [i2cm_pkg::DLY_W-1:0] h1;
  logic [i2cm_pkg::DLY_W-1:0] h2;
  logic [i2cm_pkg::DLY_W-1:0] h4;
  logic                       rejected;

  // A zero rate is taken as one tick per microsecond.
  assign tpu = (ticks_per_us == '0) ? i2cm_pkg::TPU_W'(1) : ticks_per_us;
  assign h1  = i2cm_pkg::DLY_W'(tpu);
  assign h2  = i2cm_pkg::DLY_W'({tpu, 1'b0});
  assign h4  = i2cm_pkg::DLY_W'({tpu, 2'b00});

  // Pin action of a phase and its hold time. The poll phase is handled apart.
  function automatic i2cm_pkg::seq_state_t enter_simple(
    input i2cm_pkg::seq_state_t       s,
    input logic [i2cm_pkg::PHASE_W-1:0] p,
    input logic                       sda,
    input logic [i2cm_pkg::DLY_W-1:0] d1,
    input logic [i2cm_pkg::DLY_W-1:0] d2,
    input logic [i2cm_pkg::DLY_W-1:0] d4
  );
    i2cm_pkg::seq_state_t r;
    r = s;
    r.phase = p;
    case (p)
      i2cm_pkg::ST_A: begin r.sda_en_reg = 1'b1; r.sda_reg = 1'b1; r.delay_count = d1; end
      i2cm_pkg::ST_B: begin r.scl_reg = 1'b1; r.delay_count = d4; end
      i2cm_pkg::ST_C: begin r.sda_reg = 1'b0; r.delay_count = d4; end
      i2cm_pkg::ST_D: begin r.scl_reg = 1'b0; r.delay_count = d1; end
      i2cm_pkg::SP_A: begin r.sda_en_reg = 1'b1; r.scl_reg = 1'b0; r.delay_count = d1; end
      i2cm_pkg::SP_B: begin r.sda_reg = 1'b0; r.delay_count = d4; end
      i2cm_pkg::SP_C: begin r.scl_reg = 1'b1; r.delay_count = d1; end
      i2cm_pkg::SP_D: begin r.sda_reg = 1'b1; r.delay_count = d4; end
      i2cm_pkg::WA_A: begin r.sda_en_reg = 1'b0; r.sda_reg = 1'b1; r.delay_count = d1; end
      i2cm_pkg::WA_B: begin r.scl_reg = 1'b1; r.delay_count = d1; end
      i2cm_pkg::WA_END: begin r.scl_reg = 1'b0; r.delay_count = d1; end
      i2cm_pkg::WR_A: begin
        r.sda_en_reg = 1'b1;
        r.scl_reg = 1'b0;
        r.bit_count = '0;
        r.delay_count = d1;
      end
      i2cm_pkg::WR_B: begin
        r.sda_reg = s.shift_reg[i2cm_pkg::BYTE_W-1];
        r.shift_reg = {s.shift_reg[i2cm_pkg::BYTE_W-2:0], 1'b0};
        r.delay_count = d2;
      end
      i2cm_pkg::WR_C: begin r.scl_reg = 1'b1; r.delay_count = d2; end
      i2cm_pkg::WR_D: begin r.scl_reg = 1'b0; r.delay_count = d2; end
      i2cm_pkg::RD_A: begin
        r.sda_en_reg = 1'b0;
        r.bit_count = '0;
        r.shift_reg = '0;
        r.delay_count = d2;
      end
      i2cm_pkg::RD_B: begin r.scl_reg = 1'b0; r.delay_count = d2; end
      i2cm_pkg::RD_C: begin r.scl_reg = 1'b1; r.delay_count = d2; end
      i2cm_pkg::RD_D: begin
        r.shift_reg = {s.shift_reg[i2cm_pkg::BYTE_W-2:0], sda};
        r.delay_count = d2;
      end
      i2cm_pkg::AK_A: begin r.scl_reg = 1'b0; r.delay_count = d1; end
      i2cm_pkg::AK_B: begin r.sda_en_reg = 1'b1; r.delay_count = d1; end
      i2cm_pkg::AK_C: begin r.sda_reg = ~s.ack_choice; r.delay_count = d2; end
      i2cm_pkg::AK_D: begin r.scl_reg = 1'b1; r.delay_count = d2; end
      i2cm_pkg::AK_E: begin r.scl_reg = 1'b0; r.delay_count = d1; end
      default: begin
        r.phase = i2cm_pkg::PH_IDLE;
        r.delay_count = '0;
      end
    endcase
    return r;
  endfunction

  // One acknowledge sample: a low line ends the wait, a long high line fails it.
  function automatic i2cm_pkg::seq_state_t poll(
    input i2cm_pkg::seq_state_t       s,
    input logic                       sda,
    input logic [i2cm_pkg::TMO_W-1:0] tmo,
    input logic [i2cm_pkg::DLY_W-1:0] d1,
    input logic [i2cm_pkg::DLY_W-1:0] d2,
    input logic [i2cm_pkg::DLY_W-1:0] d4
  );
    i2cm_pkg::seq_state_t r;
    logic [i2cm_pkg::WAIT_W:0] cnt;
    r = s;
    cnt = {1'b0, s.wait_count} + (i2cm_pkg::WAIT_W+1)'(1);
    if (!sda) begin
      r.ack_failed = 1'b0;
      r = enter_simple(r, i2cm_pkg::WA_END, sda, d1, d2, d4);
    end else if (cnt > {1'b0, tmo}) begin
      r.ack_failed = 1'b1;
      r = enter_simple(r, i2cm_pkg::SP_A, sda, d1, d2, d4);
    end else begin
      r.wait_count = cnt[i2cm_pkg::WAIT_W-1:0];
    end
    return r;
  endfunction

  function automatic i2cm_pkg::seq_state_t enter(
    input i2cm_pkg::seq_state_t       s,
    input logic [i2cm_pkg::PHASE_W-1:0] p,
    input logic                       sda,
    input logic [i2cm_pkg::TMO_W-1:0] tmo,
    input logic [i2cm_pkg::DLY_W-1:0] d1,
    input logic [i2cm_pkg::DLY_W-1:0] d2,
    input logic [i2cm_pkg::DLY_W-1:0] d4
  );
    i2cm_pkg::seq_state_t r;
    r = s;
    if (p == i2cm_pkg::WA_POLL) begin
      r.phase = p;
      r.wait_count = '0;
      r.delay_count = '0;
      r = poll(r, sda, tmo, d1, d2, d4);
    end else begin
      r = enter_simple(r, p, sda, d1, d2, d4);
    end
    return r;
  endfunction

  always_comb begin
    i2cm_pkg::seq_state_t       s;
    logic [i2cm_pkg::DLY_W-1:0] dly;
    logic [i2cm_pkg::BIT_W-1:0] bc;
    s = cur;
    dly = cur.delay_count;
    bc = cur.bit_count;
    rejected = 1'b0;
    if (cur.phase == i2cm_pkg::PH_IDLE) begin
      case (req_type)
        i2cm_pkg::REQ_START: s = enter(s, i2cm_pkg::ST_A, sda_level, ack_timeout, h1, h2, h4);
        i2cm_pkg::REQ_STOP:  s = enter(s, i2cm_pkg::SP_A, sda_level, ack_timeout, h1, h2, h4);
        i2cm_pkg::REQ_WRITE: begin
          s.shift_reg = tx_byte;
          s = enter(s, i2cm_pkg::WR_A, sda_level, ack_timeout, h1, h2, h4);
        end
        i2cm_pkg::REQ_WAIT:  s = enter(s, i2cm_pkg::WA_A, sda_level, ack_timeout, h1, h2, h4);
        i2cm_pkg::REQ_READ: begin
          s.ack_choice = send_ack;
          s = enter(s, i2cm_pkg::RD_A, sda_level, ack_timeout, h1, h2, h4);
        end
        default: ;
      endcase
    end else begin
      rejected = (req_type >= i2cm_pkg::REQ_START) && (req_type <= i2cm_pkg::REQ_READ);
      if (cur.phase == i2cm_pkg::WA_POLL) begin
        s = poll(s, sda_level, ack_timeout, h1, h2, h4);
      end else begin
        if (dly != '0) dly = dly - i2cm_pkg::DLY_W'(1);
        s.delay_count = dly;
        if (dly == '0) begin
          case (cur.phase)
            i2cm_pkg::ST_D, i2cm_pkg::SP_D, i2cm_pkg::WA_END: begin
              s.phase = i2cm_pkg::PH_IDLE;
              s.delay_count = '0;
            end
            i2cm_pkg::WR_D: begin
              bc = cur.bit_count + i2cm_pkg::BIT_W'(1);
              s.bit_count = bc;
              if (bc >= i2cm_pkg::BITS_PER_BYTE) begin
                s.phase = i2cm_pkg::PH_IDLE;
                s.delay_count = '0;
              end else begin
                s = enter(s, i2cm_pkg::WR_B, sda_level, ack_timeout, h1, h2, h4);
              end
            end
            i2cm_pkg::RD_D: begin
              bc = cur.bit_count + i2cm_pkg::BIT_W'(1);
              s.bit_count = bc;
              if (bc >= i2cm_pkg::BITS_PER_BYTE) begin
                s = enter(s, i2cm_pkg::AK_A, sda_level, ack_timeout, h1, h2, h4);
              end else begin
                s = enter(s, i2cm_pkg::RD_B, sda_level, ack_timeout, h1, h2, h4);
              end
            end
            i2cm_pkg::RD_A: s = enter(s, i2cm_pkg::RD_B, sda_level, ack_timeout, h1, h2, h4);
            i2cm_pkg::AK_E: begin
              s.received = cur.shift_reg;
              s.phase = i2cm_pkg::PH_IDLE;
              s.delay_count = '0;
            end
            default: begin
              s = enter(s, cur.phase + i2cm_pkg::PHASE_W'(1), sda_level, ack_timeout,
                        h1, h2, h4);
            end
          endcase
        end
      end
    end
    nxt = s;
  end

  // A sequence completes exactly when a busy phase falls back to idle.
  always_comb begin
    res.scl_level    = nxt.scl_reg;
    res.sda_out      = nxt.sda_en_reg & nxt.sda_reg;
    res.sda_drive    = nxt.sda_en_reg;
    res.busy_res     = (nxt.phase != i2cm_pkg::PH_IDLE);
    res.done_res     = (cur.phase != i2cm_pkg::PH_IDLE) && (nxt.phase == i2cm_pkg::PH_IDLE);
    res.rx_byte      = nxt.received;
    res.ack_error    = nxt.ack_failed;
    res.cmd_rejected = rejected;
  end

endmodule

/* src/i2c_master_sequencer.sv */
// ----------------------------------------------------------------------------
// I2C master sequencer
// Tick-driven I2C bus master: start, stop, write, acknowledge wait and read.
// ----------------------------------------------------------------------------
// Each accepted word on the item channel is one bus timing tick, and one tick
// is taken every clock cycle unless stalled: the sequencer state is updated
// in a single pass of next-state logic at the accepting edge, and the tick's
// pin levels and status land in a result register at that same edge. The
// result register frees the input side, so a new tick is taken in the same
// cycle that the previous result is taken; the item channel stalls only
// while a result waits and the result channel is not ready. Bus phase
// lengths are 1, 2 or 4 microseconds of ticks_per_us ticks each. There is
// no clearing pass; configuration writes are accepted in every cycle.
module i2c_master_sequencer (
  input logic           clk,
  input logic           rst,
  i2cm_cfg_if.sink      cfg,
  i2cm_item_if.sink     item,
  i2cm_result_if.source result
);

  `include "i2c_master_sequencer_macros.svh"

  logic [i2cm_pkg::TPU_W-1:0] ticks_per_us;
  logic [i2cm_pkg::TMO_W-1:0] ack_timeout;
  i2cm_pkg::seq_state_t       state;
  i2cm_pkg::seq_state_t       state_next;
  i2cm_pkg::tick_res_t        res_next;
  i2cm_pkg::tick_res_t        res;
  logic                       res_valid;
  logic                       accept;

  assign cfg.ready  = 1'b1;
  assign item.ready = !res_valid || result.ready;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= i2cm_pkg::TPU_RESET;
      ack_timeout  <= i2cm_pkg::TIMEOUT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        i2cm_pkg::CFG_TICKS_PER_US: ticks_per_us <= cfg.data[i2cm_pkg::TPU_W-1:0];
        i2cm_pkg::CFG_ACK_TIMEOUT:  ack_timeout  <= cfg.data[i2cm_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  i2cm_step u_step (
    .cur          (state),
    .req_type     (item.req_type),
    .tx_byte      (item.tx_byte),
    .send_ack     (item.send_ack),
    .sda_level    (item.sda_level),
    .ticks_per_us (ticks_per_us),
    .ack_timeout  (ack_timeout),
    .nxt          (state_next),
    .res          (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= i2cm_pkg::PH_IDLE;
      state.delay_count <= '0;
      state.bit_count   <= '0;
      state.shift_reg   <= '0;
      state.wait_count  <= '0;
      state.received    <= '0;
      state.ack_failed  <= 1'b0;
      state.scl_reg     <= 1'b1;
      state.sda_reg     <= 1'b1;
      state.sda_en_reg  <= 1'b1;
      state.ack_choice  <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

  assign result.valid        = res_valid;
  assign result.scl_level    = res.scl_level;
  assign result.sda_out      = res.sda_out;
  assign result.sda_drive    = res.sda_drive;
  assign result.busy_res     = res.busy_res;
  assign result.done_res     = res.done_res;
  assign result.rx_byte      = res.rx_byte;
  assign result.ack_error    = res.ack_error;
  assign result.cmd_rejected = res.cmd_rejected;

  // Every accepted tick leaves a result behind it.
  `I2CM_ASSERT_NEXT(a_tick_gives_result, accept, result.valid, "accepted tick left no result")

  // The reported busy flag agrees with the phase the tick left behind.
  `I2CM_ASSERT_NEXT(a_busy_matches_phase, accept, result.busy_res == (state.phase != i2cm_pkg::PH_IDLE), "busy flag disagrees with sequencer phase")

  // A waiting result blocks new ticks.
  `I2CM_ASSERT_NOW(a_full_blocks_item, result.valid && !result.ready, !item.ready, "tick accepted over a waiting result")

  // The acknowledge poll runs without a hold count.
  `I2CM_ASSERT_NOW(a_poll_no_delay, state.phase == i2cm_pkg::WA_POLL, state.delay_count == '0, "hold count set during acknowledge poll")

endmodule

/* bench/i2cm_bus_checker.sv */
// ----------------------------------------------------------------------------
// I2C master sequencer bus checker
// Watches the configuration, tick and result channels of the sequencer. It
// keeps its own copy of the bus sequencer state, works out the pin levels and
// status of every accepted tick, and compares each result word in order.
// ----------------------------------------------------------------------------
module i2cm_bus_checker (
  input  logic   clk,
  input  logic   rst,
  i2cm_cfg_if    cfg,
  i2cm_item_if   item,
  i2cm_result_if result,
  output int     fails,
  output int     pending,
  output logic   seq_busy
);
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  logic [TPU_W-1:0]   tick_div;
  logic [TMO_W-1:0]   ack_limit;
  logic [PHASE_W-1:0] bus_phase;
  logic [DLY_W-1:0]   hold_left;
  logic [BIT_W-1:0]   bits_done;
  logic [BYTE_W-1:0]  shreg;
  logic [BYTE_W-1:0]  rx_last;
  logic [WAIT_W-1:0]  high_ticks;
  logic               ack_err;
  logic               scl_q;
  logic               sda_q;
  logic               sda_en_q;
  logic               ack_answer;
  logic               seq_done;

  tick_res_t expected_ticks[$];
  tick_res_t want;
  tick_res_t seen;

  task automatic clear_model();
    tick_div   = TPU_RESET;
    ack_limit  = TIMEOUT_RESET;
    bus_phase  = PH_IDLE;
    hold_left  = '0;
    bits_done  = '0;
    shreg      = '0;
    high_ticks = '0;
    rx_last    = '0;
    ack_err    = 1'b0;
    scl_q      = 1'b1;
    sda_q      = 1'b1;
    sda_en_q   = 1'b1;
    ack_answer = 1'b0;
    seq_done   = 1'b0;
  endtask

  task automatic load_hold(input int us);
    int t;
    t = (tick_div == '0) ? 1 : int'(tick_div);
    hold_left = DLY_W'(us * t);
  endtask

  task automatic end_sequence();
    bus_phase = PH_IDLE;
    hold_left = '0;
    seq_done  = 1'b1;
  endtask

  // One SDA sample of the acknowledge wait. PH_IDLE as the next phase means
  // that polling goes on.
  task automatic sample_ack(input logic sda, output logic [PHASE_W-1:0] nxt);
    logic [WAIT_W:0] cnt;
    nxt = PH_IDLE;
    if (!sda) begin
      ack_err = 1'b0;
      nxt = WA_END;
    end else begin
      cnt = {1'b0, high_ticks} + (WAIT_W+1)'(1);
      if (cnt > {1'b0, ack_limit}) begin
        ack_err = 1'b1;
        nxt = SP_A;
      end else begin
        high_ticks = cnt[WAIT_W-1:0];
      end
    end
  endtask

  task automatic enter_phase(input logic [PHASE_W-1:0] p, input logic sda);
    logic [PHASE_W-1:0] cur;
    logic [PHASE_W-1:0] nxt;
    logic               again;
    cur = p;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      bus_phase = cur;
      case (cur)
        ST_A: begin sda_en_q = 1'b1; sda_q = 1'b1; load_hold(1); end
        ST_B: begin scl_q = 1'b1; load_hold(4); end
        ST_C: begin sda_q = 1'b0; load_hold(4); end
        ST_D: begin scl_q = 1'b0; load_hold(1); end
        SP_A: begin sda_en_q = 1'b1; scl_q = 1'b0; load_hold(1); end
        SP_B: begin sda_q = 1'b0; load_hold(4); end
        SP_C: begin scl_q = 1'b1; load_hold(1); end
        SP_D: begin sda_q = 1'b1; load_hold(4); end
        WA_A: begin sda_en_q = 1'b0; sda_q = 1'b1; load_hold(1); end
        WA_B: begin scl_q = 1'b1; load_hold(1); end
        WA_POLL: begin
          // The first sample is taken on the tick that enters the poll.
          high_ticks = '0;
          hold_left = '0;
          sample_ack(sda, nxt);
          if (nxt != PH_IDLE) begin
            cur = nxt;
            again = 1'b1;
          end
        end
        WA_END: begin scl_q = 1'b0; load_hold(1); end
        WR_A: begin sda_en_q = 1'b1; scl_q = 1'b0; bits_done = '0; load_hold(1); end
        WR_B: begin
          sda_q = shreg[BYTE_W-1];
          shreg = shreg << 1;
          load_hold(2);
        end
        WR_C: begin scl_q = 1'b1; load_hold(2); end
        WR_D: begin scl_q = 1'b0; load_hold(2); end
        RD_A: begin sda_en_q = 1'b0; bits_done = '0; shreg = '0; load_hold(2); end
        RD_B: begin scl_q = 1'b0; load_hold(2); end
        RD_C: begin scl_q = 1'b1; load_hold(2); end
        RD_D: begin shreg = {shreg[BYTE_W-2:0], sda}; load_hold(2); end
        AK_A: begin scl_q = 1'b0; load_hold(1); end
        AK_B: begin sda_en_q = 1'b1; load_hold(1); end
        AK_C: begin sda_q = ~ack_answer; load_hold(2); end
        AK_D: begin scl_q = 1'b1; load_hold(2); end
        AK_E: begin scl_q = 1'b0; load_hold(1); end
        default: end_sequence();
      endcase
    end
  endtask

  task automatic phase_expired(input logic sda);
    case (bus_phase)
      ST_D, SP_D, WA_END: end_sequence();
      WR_D: begin
        bits_done = bits_done + BIT_W'(1);
        if (bits_done >= BITS_PER_BYTE) end_sequence();
        else enter_phase(WR_B, sda);
      end
      RD_D: begin
        bits_done = bits_done + BIT_W'(1);
        if (bits_done >= BITS_PER_BYTE) enter_phase(AK_A, sda);
        else enter_phase(RD_B, sda);
      end
      RD_A: enter_phase(RD_B, sda);
      AK_E: begin
        rx_last = shreg;
        end_sequence();
      end
      default: enter_phase(bus_phase + PHASE_W'(1), sda);
    endcase
  endtask

  task automatic predict_tick(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] tx,
                              input logic snd_ack, input logic sda);
    logic [PHASE_W-1:0] nxt;
    logic               rejected;
    tick_res_t          r;
    seq_done = 1'b0;
    rejected = 1'b0;
    if (bus_phase == PH_IDLE) begin
      case (req)
        REQ_START: enter_phase(ST_A, sda);
        REQ_STOP:  enter_phase(SP_A, sda);
        REQ_WRITE: begin shreg = tx; enter_phase(WR_A, sda); end
        REQ_WAIT:  enter_phase(WA_A, sda);
        REQ_READ:  begin ack_answer = snd_ack; enter_phase(RD_A, sda); end
        default: ;
      endcase
    end else begin
      rejected = (req >= REQ_START) && (req <= REQ_READ);
      if (bus_phase == WA_POLL) begin
        sample_ack(sda, nxt);
        if (nxt != PH_IDLE) enter_phase(nxt, sda);
      end else begin
        if (hold_left != '0) hold_left = hold_left - DLY_W'(1);
        if (hold_left == '0) phase_expired(sda);
      end
    end
    r.scl_level    = scl_q;
    r.sda_out      = sda_en_q ? sda_q : 1'b0;
    r.sda_drive    = sda_en_q;
    r.busy_res     = (bus_phase != PH_IDLE);
    r.done_res     = seq_done;
    r.rx_byte      = rx_last;
    r.ack_error    = ack_err;
    r.cmd_rejected = rejected;
    expected_ticks.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                             input logic [BYTE_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      expected_ticks.delete();
    end else begin
      // The result word at this edge belongs to a tick taken earlier, so it
      // is matched before this edge's tick is predicted.
      if (result.valid && result.ready) begin
        seen.scl_level    = result.scl_level;
        seen.sda_out      = result.sda_out;
        seen.sda_drive    = result.sda_drive;
        seen.busy_res     = result.busy_res;
        seen.done_res     = result.done_res;
        seen.rx_byte      = result.rx_byte;
        seen.ack_error    = result.ack_error;
        seen.cmd_rejected = result.cmd_rejected;
        if (expected_ticks.size() == 0) begin
          $display("%0t ns: result word with nothing expected, expected none, actual %h",
                   $time, seen);
          fails++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("scl_level", BYTE_W'(want.scl_level), BYTE_W'(seen.scl_level));
          check_field("sda_out", BYTE_W'(want.sda_out), BYTE_W'(seen.sda_out));
          check_field("sda_drive", BYTE_W'(want.sda_drive), BYTE_W'(seen.sda_drive));
          check_field("busy_res", BYTE_W'(want.busy_res), BYTE_W'(seen.busy_res));
          check_field("done_res", BYTE_W'(want.done_res), BYTE_W'(seen.done_res));
          check_field("rx_byte", want.rx_byte, seen.rx_byte);
          check_field("ack_error", BYTE_W'(want.ack_error), BYTE_W'(seen.ack_error));
          check_field("cmd_rejected", BYTE_W'(want.cmd_rejected),
                      BYTE_W'(seen.cmd_rejected));
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_TICKS_PER_US) tick_div = cfg.data[TPU_W-1:0];
        else if (cfg.index == CFG_ACK_TIMEOUT) ack_limit = cfg.data[TMO_W-1:0];
      end
      if (item.valid && item.ready) begin
        predict_tick(item.req_type, item.tx_byte, item.send_ack, item.sda_level);
      end
    end
    pending  = expected_ticks.size();
    seq_busy = (bus_phase != PH_IDLE);
  end

endmodule

/* bench/tb_i2c_master_sequencer.sv */
// ----------------------------------------------------------------------------
// I2C master sequencer testbench
// Drives bus ticks carrying commands and SDA samples through several timing
// settings, with random stalls on both channels; the bus checker predicts
// and compares every result word, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_i2c_master_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  // Command codes that the sequencer leaves unused.
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  bit               idle_on = 1'b1;
  int               items_sent = 0;
  logic [TPU_W-1:0] tpu_set = TPU_RESET;
  logic [TMO_W-1:0] tmo_set = TIMEOUT_RESET;
  int               fail_count;
  int               pending_count;
  logic             pred_busy;

  i2cm_item_if   item_ch ();
  i2cm_result_if res_ch ();
  i2cm_cfg_if    cfg_ch ();

  i2c_master_sequencer i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (res_ch)
  );

  i2cm_bus_checker i_chk (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_ch),
    .item     (item_ch),
    .result   (res_ch),
    .fails    (fail_count),
    .pending  (pending_count),
    .seq_busy (pred_busy)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("i2c_master_sequencer test failed");
    $finish;
  end

  // Result side back-pressure.
  initial begin
    int stall_left;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && stall_left == 0 && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] tx,
                           input logic snd_ack, input logic sda);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.req_type  <= req;
    item_ch.tx_byte   <= tx;
    item_ch.send_ack  <= snd_ack;
    item_ch.sda_level <= sda;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Hold off until every result word is in and the bus sequence has ended,
  // feeding empty ticks while a cut-short sequence is still running.
  task automatic settle();
    forever begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
      wait (pending_count == 0);
      if (!pred_busy) break;
      send_tick(REQ_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
    end
    repeat (2) @(posedge clk);
  endtask

  // One command and the ticks that it needs. For an acknowledge wait, SDA is
  // held high for k samples of the poll and then pulled low.
  task automatic issue_command(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] tx,
                               input logic snd_ack, input int k);
    int u;
    int dur;
    logic [REQ_W-1:0] code;
    logic sda;
    u = (tpu_set == '0) ? 1 : int'(tpu_set);
    case (req)
      REQ_WRITE: dur = 49 * u;
      REQ_READ:  dur = 57 * u;
      REQ_WAIT:  dur = (k <= int'(tmo_set)) ? 3 * u + k : 12 * u + int'(tmo_set);
      default:   dur = 10 * u;
    endcase
    send_tick(req, tx, snd_ack, 1'($urandom));
    // Now and then the sequence is cut short so that the next command
    // lands while the bus is still busy.
    if ($urandom_range(0, 11) == 0) dur = $urandom_range(0, dur);
    for (int i = 1; i <= dur; i++) begin
      code = REQ_NONE;
      if ($urandom_range(0, 15) == 0) code = REQ_W'($urandom_range(REQ_START, REQ_SPARE_HI));
      sda = 1'($urandom);
      if (req == REQ_WAIT && i >= 2 * u) sda = (i < 2 * u + k);
      send_tick(code, 8'($urandom), 1'($urandom), sda);
    end
    repeat ($urandom_range(0, 2)) send_tick(REQ_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic run_command();
    int r;
    int k;
    int lim;
    logic [REQ_W-1:0]  req;
    logic [BYTE_W-1:0] tx;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      repeat ($urandom_range(1, 5)) send_tick(REQ_NONE, 8'($urandom), 1'($urandom),
                                              1'($urandom));
    end else if (r == 1) begin
      send_tick($urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO, 8'($urandom),
                1'($urandom), 1'($urandom));
    end else begin
      case ($urandom_range(0, 4))
        0: req = REQ_START;
        1: req = REQ_STOP;
        2: req = REQ_WRITE;
        3: req = REQ_WAIT;
        default: req = REQ_READ;
      endcase
      case ($urandom_range(0, 3))
        0: tx = 8'h00;
        1: tx = 8'hFF;
        default: tx = 8'($urandom);
      endcase
      lim = (int'(tmo_set) + 2 < 12) ? int'(tmo_set) + 2 : 12;
      if (int'(tmo_set) <= 40 && $urandom_range(0, 3) == 0) k = int'(tmo_set) + 1;
      else k = $urandom_range(0, lim);
      issue_command(req, tx, 1'($urandom), k);
    end
  endtask

  task automatic run_phase(input logic [TPU_W-1:0] tpu, input logic [TMO_W-1:0] tmo,
                           input int n, input bit idle);
    int target;
    settle();
    idle_on = idle;
    write_reg(CFG_TICKS_PER_US, CFG_DATA_W'(tpu));
    write_reg(CFG_ACK_TIMEOUT, CFG_DATA_W'(tmo));
    tpu_set = tpu;
    tmo_set = tmo;
    target = items_sent + n;
    while (items_sent < target) run_command();
  endtask

  initial begin
    item_ch.valid     = 1'b0;
    item_ch.req_type  = REQ_NONE;
    item_ch.tx_byte   = '0;
    item_ch.send_ack  = 1'b0;
    item_ch.sda_level = 1'b1;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_TICKS_PER_US;
    cfg_ch.data       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed ticks at the reset timing of one tick per microsecond.
    send_tick(REQ_NONE, 8'h00, 1'b0, 1'b0);
    send_tick(REQ_SPARE_LO, 8'hFF, 1'b1, 1'b1);
    send_tick(REQ_SPARE_HI, 8'hFF, 1'b1, 1'b1);
    // Start, with a command while busy, an unused code while busy, and a
    // command on the completion word.
    send_tick(REQ_START, 8'h00, 1'b0, 1'b0);
    for (int i = 1; i <= 10; i++) begin
      send_tick(i == 3 ? REQ_WRITE : i == 5 ? REQ_SPARE_LO : i == 10 ? REQ_STOP : REQ_NONE,
                8'h5A, 1'b1, 1'(i));
    end
    send_tick(REQ_STOP, 8'hFF, 1'b0, 1'b1);
    repeat (10) send_tick(REQ_NONE, 8'h00, 1'b0, 1'b1);
    // Acknowledge seen on the very first poll sample.
    send_tick(REQ_WAIT, 8'h00, 1'b0, 1'b1);
    send_tick(REQ_NONE, 8'h00, 1'b0, 1'b1);
    send_tick(REQ_NONE, 8'h00, 1'b0, 1'b0);
    send_tick(REQ_NONE, 8'h00, 1'b0, 1'b1);

    run_phase(8'd1, 10'd1, 150, 1'b1);
    run_phase(8'd2, 10'd0, 100, 1'b1);
    run_phase(8'd0, 10'd6, 100, 1'b1);
    run_phase(8'd3, 10'd1023, 120, 1'b1);
    // Slow timing: a single acknowledge wait that is answered at once.
    run_phase(8'd60, 10'd1023, 0, 1'b1);
    issue_command(REQ_WAIT, 8'h00, 1'b0, 0);
    run_phase(8'd4, 10'd17, 100, 1'b0);

    @(negedge clk);
    item_ch.valid <= 1'b0;
    wait (pending_count == 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("i2c_master_sequencer test passed");
    end else begin
      $display("i2c_master_sequencer test failed");
    end
    $finish;
  end

endmodule
